/* rtl/irsd_pkg.sv */
// ----------------------------------------------------------------------------
// irsd_pkg
// Shared types and constants of the index record stream decoder.
// ----------------------------------------------------------------------------
package irsd_pkg;

    localparam int IRSD_QUEUE_DEPTH = 4;

    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_DOC    = 2'd1;
    localparam logic [1:0] KIND_END    = 2'd2;
    localparam logic [1:0] KIND_ERROR  = 2'd3;

    localparam logic [1:0] ERR_LENGTH    = 2'd0;
    localparam logic [1:0] ERR_OVERRUN   = 2'd1;
    localparam logic [1:0] ERR_ALIGN     = 2'd2;
    localparam logic [1:0] ERR_TRUNCATED = 2'd3;

    localparam logic [1:0] PHASE_LAST = 2'd3;

    typedef enum logic [5:0] {
        SLOT_OUTER = 6'b000001,
        SLOT_TERM  = 6'b000010,
        SLOT_CAT   = 6'b000100,
        SLOT_FREQ  = 6'b001000,
        SLOT_LIST  = 6'b010000,
        SLOT_DOC   = 6'b100000
    } t_slot;

    typedef struct packed {
        logic        has_data;
        logic        data_is_doc;
        logic [31:0] term;
        logic [31:0] category;
        logic [31:0] frequency;
        logic [31:0] word;
        logic        has_close;
        logic [1:0]  close_kind;
        logic [1:0]  close_err;
    } t_cmd;

endpackage

/* rtl/irsd_front.sv */
// ----------------------------------------------------------------------------
// irsd_front
// Byte parser: accepts one byte per cycle unless i_full, tracks fields and
// lengths, and builds one queue command for each byte that causes results.
// ----------------------------------------------------------------------------
module irsd_front
    import irsd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_data_byte,
    input  logic       i_last_byte,
    input  logic       i_full,
    output logic       o_push,
    output t_cmd       o_cmd
);

    t_slot       r_slot, n_slot;
    logic [1:0]  r_phase, n_phase;
    logic [23:0] r_word_bytes, n_word_bytes;
    logic [31:0] r_rec_rem, n_rec_rem;
    logic [31:0] r_list_rem, n_list_rem;
    logic [31:0] r_term, n_term;
    logic [31:0] r_cat, n_cat;
    logic [31:0] r_freq, n_freq;
    logic        r_fault, n_fault;
    logic [1:0]  r_fault_code, n_fault_code;

    logic        w_accept;
    logic        w_decode;
    logic [31:0] w_word;
    t_cmd        w_cmd;

    assign w_accept = i_valid && !i_full;
    assign w_word   = {i_data_byte, r_word_bytes};

    always_comb begin
        n_slot       = r_slot;
        n_phase      = r_phase;
        n_word_bytes = r_word_bytes;
        n_rec_rem    = r_rec_rem;
        n_list_rem   = r_list_rem;
        n_term       = r_term;
        n_cat        = r_cat;
        n_freq       = r_freq;
        n_fault      = r_fault;
        n_fault_code = r_fault_code;
        w_cmd        = '0;
        w_decode     = 1'b1;

        if (r_slot != SLOT_OUTER) begin
            if (r_rec_rem == 32'd0) begin
                n_fault      = 1'b1;
                n_fault_code = ERR_LENGTH;
                w_decode     = 1'b0;
            end else begin
                n_rec_rem = r_rec_rem - 32'd1;
            end
        end
        if (n_fault) begin
            w_decode = 1'b0;
        end

        if (w_decode) begin
            if (r_phase != PHASE_LAST) begin
                case (r_phase)
                    2'd0:    n_word_bytes[7:0]   = i_data_byte;
                    2'd1:    n_word_bytes[15:8]  = i_data_byte;
                    default: n_word_bytes[23:16] = i_data_byte;
                endcase
                n_phase = r_phase + 2'd1;
            end else begin
                n_phase      = 2'd0;
                n_word_bytes = '0;
                unique case (r_slot)
                    SLOT_OUTER: begin
                        n_rec_rem = w_word;
                        n_slot    = SLOT_TERM;
                    end
                    SLOT_TERM: begin
                        n_term = w_word;
                        n_slot = SLOT_CAT;
                    end
                    SLOT_CAT: begin
                        n_cat  = w_word;
                        n_slot = SLOT_FREQ;
                    end
                    SLOT_FREQ: begin
                        n_freq = w_word;
                        n_slot = SLOT_LIST;
                    end
                    SLOT_LIST: begin
                        if (w_word > n_rec_rem) begin
                            n_fault      = 1'b1;
                            n_fault_code = ERR_OVERRUN;
                        end else if (w_word[1:0] != 2'd0) begin
                            n_fault      = 1'b1;
                            n_fault_code = ERR_ALIGN;
                        end else begin
                            n_list_rem        = w_word;
                            w_cmd.has_data    = 1'b1;
                            w_cmd.data_is_doc = 1'b0;
                            w_cmd.term        = r_term;
                            w_cmd.category    = r_cat;
                            w_cmd.frequency   = r_freq;
                            w_cmd.word        = w_word;
                            n_slot = (w_word != 32'd0) ? SLOT_DOC : SLOT_TERM;
                        end
                    end
                    SLOT_DOC: begin
                        w_cmd.has_data    = 1'b1;
                        w_cmd.data_is_doc = 1'b1;
                        w_cmd.term        = r_term;
                        w_cmd.category    = r_cat;
                        w_cmd.frequency   = r_freq;
                        w_cmd.word        = w_word;
                        n_list_rem = (r_list_rem >= 32'd4) ? r_list_rem - 32'd4 : 32'd0;
                        if (n_list_rem == 32'd0) begin
                            n_slot = SLOT_TERM;
                        end
                    end
                    default: begin
                        n_slot = SLOT_OUTER;
                    end
                endcase
            end
        end

        if (i_last_byte) begin
            w_cmd.has_close  = 1'b1;
            w_cmd.close_kind = KIND_ERROR;
            w_cmd.close_err  = ERR_LENGTH;
            if (n_slot == SLOT_OUTER) begin
                w_cmd.close_err = ERR_TRUNCATED;
            end else if (n_rec_rem != 32'd0) begin
                w_cmd.close_err = ERR_LENGTH;
            end else if (n_fault) begin
                w_cmd.close_err = n_fault_code;
            end else if (n_slot == SLOT_TERM && n_phase == 2'd0) begin
                w_cmd.close_kind = KIND_END;
            end else begin
                w_cmd.close_err = ERR_TRUNCATED;
            end
            n_slot       = SLOT_OUTER;
            n_phase      = 2'd0;
            n_word_bytes = '0;
            n_rec_rem    = '0;
            n_list_rem   = '0;
            n_term       = '0;
            n_cat        = '0;
            n_freq       = '0;
            n_fault      = 1'b0;
            n_fault_code = ERR_LENGTH;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot       <= SLOT_OUTER;
            r_phase      <= 2'd0;
            r_word_bytes <= '0;
            r_rec_rem    <= '0;
            r_list_rem   <= '0;
            r_term       <= '0;
            r_cat        <= '0;
            r_freq       <= '0;
            r_fault      <= 1'b0;
            r_fault_code <= ERR_LENGTH;
        end else if (w_accept) begin
            r_slot       <= n_slot;
            r_phase      <= n_phase;
            r_word_bytes <= n_word_bytes;
            r_rec_rem    <= n_rec_rem;
            r_list_rem   <= n_list_rem;
            r_term       <= n_term;
            r_cat        <= n_cat;
            r_freq       <= n_freq;
            r_fault      <= n_fault;
            r_fault_code <= n_fault_code;
        end
    end

    assign o_push = w_accept && (w_cmd.has_data || w_cmd.has_close);
    assign o_cmd  = w_cmd;

endmodule

/* rtl/irsd_queue.sv */
// ----------------------------------------------------------------------------
// irsd_queue
// Short command queue between the parser and the result stage.
// ----------------------------------------------------------------------------
module irsd_queue
    import irsd_pkg::*;
#(
    parameter int QUEUE_DEPTH = IRSD_QUEUE_DEPTH
)(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output logic o_full,
    output logic o_empty,
    output t_cmd o_head
);

    localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CntW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PtrW-1:0] PtrMax = PtrW'(QUEUE_DEPTH - 1);
    localparam logic [CntW-1:0] CntFull = CntW'(QUEUE_DEPTH);

    t_cmd            r_mem [QUEUE_DEPTH];
    logic [PtrW-1:0] r_wr, n_wr;
    logic [PtrW-1:0] r_rd, n_rd;
    logic [CntW-1:0] r_cnt, n_cnt;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == PtrMax) ? '0 : r_wr + PtrW'(1);
        end
        if (i_pop) begin
            n_rd = (r_rd == PtrMax) ? '0 : r_rd + PtrW'(1);
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + CntW'(1);
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - CntW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    assign o_full  = (r_cnt == CntFull);
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd];

endmodule

/* rtl/irsd_back.sv */
// ----------------------------------------------------------------------------
// irsd_back
// Result stage: expands each queue command into its data result, its closing
// result or both, and holds each in the output register in turn.
// ----------------------------------------------------------------------------
module irsd_back
    import irsd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_empty,
    input  t_cmd        i_q_head,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_kind,
    output logic [31:0] o_term_id,
    output logic [31:0] o_category,
    output logic [31:0] o_frequency,
    output logic [29:0] o_doc_count,
    output logic [31:0] o_doc_id,
    output logic [1:0]  o_error_code,
    output logic        o_last
);

    logic        r_valid;
    logic        r_pend_close;
    logic [1:0]  r_close_kind;
    logic [1:0]  r_close_err;
    logic [1:0]  r_kind;
    logic [31:0] r_term;
    logic [31:0] r_cat;
    logic [31:0] r_freq;
    logic [29:0] r_count;
    logic [31:0] r_doc;
    logic [1:0]  r_err;
    logic        r_last;

    logic w_free;

    assign w_free = !r_valid || !i_stall;
    assign o_pop  = w_free && !r_pend_close && !i_q_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= 1'b0;
            r_pend_close <= 1'b0;
        end else if (w_free) begin
            if (r_pend_close) begin
                r_valid      <= 1'b1;
                r_pend_close <= 1'b0;
            end else if (!i_q_empty) begin
                r_valid      <= 1'b1;
                r_pend_close <= i_q_head.has_data && i_q_head.has_close;
            end else begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_free) begin
            if (r_pend_close) begin
                r_kind  <= r_close_kind;
                r_term  <= '0;
                r_cat   <= '0;
                r_freq  <= '0;
                r_count <= '0;
                r_doc   <= '0;
                r_err   <= (r_close_kind == KIND_ERROR) ? r_close_err : ERR_LENGTH;
                r_last  <= 1'b1;
            end else if (!i_q_empty) begin
                r_close_kind <= i_q_head.close_kind;
                r_close_err  <= i_q_head.close_err;
                if (i_q_head.has_data) begin
                    r_kind  <= i_q_head.data_is_doc ? KIND_DOC : KIND_HEADER;
                    r_term  <= i_q_head.term;
                    r_cat   <= i_q_head.category;
                    r_freq  <= i_q_head.frequency;
                    r_count <= i_q_head.data_is_doc ? 30'd0 : i_q_head.word[31:2];
                    r_doc   <= i_q_head.data_is_doc ? i_q_head.word : 32'd0;
                    r_err   <= ERR_LENGTH;
                    r_last  <= 1'b0;
                end else begin
                    r_kind  <= i_q_head.close_kind;
                    r_term  <= '0;
                    r_cat   <= '0;
                    r_freq  <= '0;
                    r_count <= '0;
                    r_doc   <= '0;
                    r_err   <= (i_q_head.close_kind == KIND_ERROR) ?
                               i_q_head.close_err : ERR_LENGTH;
                    r_last  <= 1'b1;
                end
            end
        end
    end

    assign o_valid      = r_valid;
    assign o_kind       = r_kind;
    assign o_term_id    = r_term;
    assign o_category   = r_cat;
    assign o_frequency  = r_freq;
    assign o_doc_count  = r_count;
    assign o_doc_id     = r_doc;
    assign o_error_code = r_err;
    assign o_last       = r_last;

endmodule

/* rtl/index_record_stream_decoder_top.sv */
// Each result passes through the command queue and then the output register.
// Throughput: one byte per cycle while o_stall is low; a last byte that yields
// a data result is followed by its closing result from the output stage.
// The parser accepts bytes while the command queue has room.
// Reset is synchronous and active low; it clears the parser, queue and output.
// ----------------------------------------------------------------------------
// index_record_stream_decoder_top
// Decodes a length-prefixed inverted-index term record, one byte per item.
// ----------------------------------------------------------------------------
module index_record_stream_decoder_top
    import irsd_pkg::*;
#(
    parameter int QUEUE_DEPTH = IRSD_QUEUE_DEPTH
)(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_kind,
    output logic [31:0] o_term_id,
    output logic [31:0] o_category,
    output logic [31:0] o_frequency,
    output logic [29:0] o_doc_count,
    output logic [31:0] o_doc_id,
    output logic [1:0]  o_error_code,
    output logic        o_last
);

    logic w_push;
    logic w_pop;
    logic w_full;
    logic w_empty;
    t_cmd w_cmd;
    t_cmd w_head;

    irsd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .i_full      (w_full),
        .o_push      (w_push),
        .o_cmd       (w_cmd)
    );

    irsd_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_cmd),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_head  (w_head)
    );

    irsd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_empty    (w_empty),
        .i_q_head     (w_head),
        .o_pop        (w_pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_kind       (o_kind),
        .o_term_id    (o_term_id),
        .o_category   (o_category),
        .o_frequency  (o_frequency),
        .o_doc_count  (o_doc_count),
        .o_doc_id     (o_doc_id),
        .o_error_code (o_error_code),
        .o_last       (o_last)
    );

    assign o_stall = w_full;

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_full)
        else $error("Command pushed into a full queue.");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_empty)
        else $error("Command popped from an empty queue.");

    a_last_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_last == (o_kind == KIND_END || o_kind == KIND_ERROR)))
        else $error("Closing flag does not match the result kind.");

    a_last_byte_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && i_last_byte) |-> w_push)
        else $error("Last byte accepted without a closing command.");

endmodule

/* bench/index_record_decode_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// index_record_decode_checker
// Watches both channels of the index record stream decoder. It parses every
// accepted byte on its own copy of the record state, queues the results the
// byte should produce and compares each accepted result with the oldest one.
// ----------------------------------------------------------------------------
module index_record_decode_checker
    import irsd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [1:0]  i_kind,
    input  logic [31:0] i_term_id,
    input  logic [31:0] i_category,
    input  logic [31:0] i_frequency,
    input  logic [29:0] i_doc_count,
    input  logic [31:0] i_doc_id,
    input  logic [1:0]  i_error_code,
    input  logic        i_last,
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] term_id;
        logic [31:0] category;
        logic [31:0] frequency;
        logic [29:0] doc_count;
        logic [31:0] doc_id;
        logic [1:0]  error_code;
        logic        last;
    } t_decoded;

    t_decoded    decoded_q[$];
    int          fail_count = 0;
    int          pending = 0;

    t_slot       slot;
    logic [1:0]  phase;
    logic [23:0] word_acc;
    logic [31:0] rec_left;
    logic [31:0] list_left;
    logic [31:0] held_term;
    logic [31:0] held_cat;
    logic [31:0] held_freq;
    logic        fault;
    logic [1:0]  fault_code;

    assign o_fail_count = fail_count;
    assign o_pending    = pending;

    task automatic clear_parser();
        slot       = SLOT_OUTER;
        phase      = '0;
        word_acc   = '0;
        rec_left   = '0;
        list_left  = '0;
        held_term  = '0;
        held_cat   = '0;
        held_freq  = '0;
        fault      = 1'b0;
        fault_code = ERR_LENGTH;
    endtask

    task automatic add_expected(input t_decoded entry);
        decoded_q.insert(decoded_q.size(), entry);
    endtask

    task automatic decode_record_byte(input logic [7:0] data, input logic is_last);
        logic        take;
        logic [31:0] word;
        logic [1:0]  close_kind;
        logic [1:0]  close_err;
        take = 1'b1;
        // Once past the outer length, every byte must fit inside the record.
        if (slot != SLOT_OUTER) begin
            if (rec_left == 0) begin
                fault      = 1'b1;
                fault_code = ERR_LENGTH;
                take       = 1'b0;
            end else begin
                rec_left = rec_left - 1;
            end
        end
        if (fault) begin
            take = 1'b0;
        end
        if (take) begin
            if (phase != PHASE_LAST) begin
                word_acc[8*phase +: 8] = data;
                phase = phase + 1'b1;
            end else begin
                word     = {data, word_acc};
                phase    = '0;
                word_acc = '0;
                case (slot)
                    SLOT_OUTER: begin
                        rec_left = word;
                        slot     = SLOT_TERM;
                    end
                    SLOT_TERM: begin
                        held_term = word;
                        slot      = SLOT_CAT;
                    end
                    SLOT_CAT: begin
                        held_cat = word;
                        slot     = SLOT_FREQ;
                    end
                    SLOT_FREQ: begin
                        held_freq = word;
                        slot      = SLOT_LIST;
                    end
                    SLOT_LIST: begin
                        if (word > rec_left) begin
                            fault      = 1'b1;
                            fault_code = ERR_OVERRUN;
                        end else if (word[1:0] != 2'b00) begin
                            fault      = 1'b1;
                            fault_code = ERR_ALIGN;
                        end else begin
                            list_left = word;
                            add_expected('{KIND_HEADER, held_term, held_cat,
                                held_freq, word[31:2], '0, '0, 1'b0});
                            slot = (word != 0) ? SLOT_DOC : SLOT_TERM;
                        end
                    end
                    default: begin
                        add_expected('{KIND_DOC, held_term, held_cat,
                            held_freq, '0, word, '0, 1'b0});
                        list_left = (list_left >= 4) ? list_left - 4 : '0;
                        if (list_left == 0) begin
                            slot = SLOT_TERM;
                        end
                    end
                endcase
            end
        end
        if (is_last) begin
            close_kind = KIND_ERROR;
            close_err  = ERR_LENGTH;
            if (slot == SLOT_OUTER) begin
                close_err = ERR_TRUNCATED;
            end else if (rec_left != 0) begin
                close_err = ERR_LENGTH;
            end else if (fault) begin
                close_err = fault_code;
            end else if (slot == SLOT_TERM && phase == 0) begin
                close_kind = KIND_END;
            end else begin
                close_err = ERR_TRUNCATED;
            end
            if (close_kind == KIND_END) begin
                close_err = '0;
            end
            add_expected('{close_kind, '0, '0, '0, '0, '0, close_err, 1'b1});
            clear_parser();
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_decoded want;
        if (!i_rst_n) begin
            clear_parser();
            decoded_q.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (decoded_q.size() == 0) begin
                    $error("result of kind %0d arrived with nothing expected", i_kind);
                    fail_count++;
                end else begin
                    want = decoded_q.pop_front();
                    check_field("kind", 32'(want.kind), 32'(i_kind));
                    check_field("term_id", want.term_id, i_term_id);
                    check_field("category", want.category, i_category);
                    check_field("frequency", want.frequency, i_frequency);
                    check_field("doc_count", 32'(want.doc_count), 32'(i_doc_count));
                    check_field("doc_id", want.doc_id, i_doc_id);
                    check_field("error_code", 32'(want.error_code), 32'(i_error_code));
                    check_field("last", 32'(want.last), 32'(i_last));
                end
            end
            if (i_in_valid && !i_in_stall) begin
                decode_record_byte(i_data_byte, i_last_byte);
            end
        end
        pending = decoded_q.size();
    end

endmodule

/* bench/tb_index_record_stream_decoder_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_index_record_stream_decoder_top
// Feeds the decoder short hand-made records, then random records, most of
// them well formed and the rest damaged in the ways the format can fail,
// under several idle and stall mixes. A checker beside the block predicts
// and compares every result.
// ----------------------------------------------------------------------------
module tb_index_record_stream_decoder_top;

    localparam int ITEM_TARGET = 1150;
    localparam int HOLD_CYCLES = 400;

    typedef enum int {
        FLAW_NONE,
        FLAW_LEN_OFF,
        FLAW_EXTRA,
        FLAW_CUT,
        FLAW_OVERRUN,
        FLAW_ALIGN,
        FLAW_PARTIAL,
        FLAW_NOISE
    } t_flaw;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic [7:0]  i_data_byte = '0;
    logic        i_last_byte = 1'b0;
    logic        i_stall = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [1:0]  o_kind;
    logic [31:0] o_term_id;
    logic [31:0] o_category;
    logic [31:0] o_frequency;
    logic [29:0] o_doc_count;
    logic [31:0] o_doc_id;
    logic [1:0]  o_error_code;
    logic        o_last;

    int          fail_count;
    int          pending;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          hold_request = 0;
    int          hold_served = 0;
    int          hold_left = 0;
    int          bytes_sent = 0;
    logic [7:0]  rec_bytes[$];

    index_record_stream_decoder_top uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_data_byte  (i_data_byte),
        .i_last_byte  (i_last_byte),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_kind       (o_kind),
        .o_term_id    (o_term_id),
        .o_category   (o_category),
        .o_frequency  (o_frequency),
        .o_doc_count  (o_doc_count),
        .o_doc_id     (o_doc_id),
        .o_error_code (o_error_code),
        .o_last       (o_last)
    );

    index_record_decode_checker checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_stall   (o_stall),
        .i_data_byte  (i_data_byte),
        .i_last_byte  (i_last_byte),
        .i_out_valid  (o_valid),
        .i_out_stall  (i_stall),
        .i_kind       (o_kind),
        .i_term_id    (o_term_id),
        .i_category   (o_category),
        .i_frequency  (o_frequency),
        .i_doc_count  (o_doc_count),
        .i_doc_id     (o_doc_id),
        .i_error_code (o_error_code),
        .i_last       (o_last),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // A requested hold keeps the output stalled for a long stretch.
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_stall   <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_served != hold_request) begin
            i_stall     <= 1'b1;
            hold_served <= hold_served + 1;
            hold_left   <= HOLD_CYCLES;
        end else begin
            i_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    function automatic logic [31:0] rand_word();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            2:       return $urandom_range(255);
            default: return $urandom();
        endcase
    endfunction

    task automatic push_word(input logic [31:0] word);
        int k;
        for (k = 0; k < 4; k++) begin
            rec_bytes.insert(rec_bytes.size(), word[8*k +: 8]);
        end
    endtask

    task automatic push_noise(input int count);
        int k;
        for (k = 0; k < count; k++) begin
            rec_bytes.insert(rec_bytes.size(), 8'($urandom_range(255)));
        end
    endtask

    task automatic build_record(input t_flaw flaw);
        int          n_entries;
        int          n_docs;
        int          e;
        int          d;
        int          cut;
        logic [31:0] list_len;
        logic [31:0] outer_len;
        rec_bytes.delete();
        if (flaw == FLAW_NOISE) begin
            push_noise($urandom_range(1, 12));
        end else begin
            push_word('0);
            n_entries = $urandom_range(2);
            if ((flaw == FLAW_OVERRUN || flaw == FLAW_ALIGN) && n_entries == 0) begin
                n_entries = 1;
            end
            for (e = 0; e < n_entries; e++) begin
                n_docs = $urandom_range(3);
                push_word(rand_word());
                push_word(rand_word());
                push_word(rand_word());
                list_len = 4 * n_docs;
                if (e == n_entries - 1 && flaw == FLAW_OVERRUN) begin
                    list_len = list_len + $urandom_range(1, 12);
                end
                if (e == n_entries - 1 && flaw == FLAW_ALIGN) begin
                    if (n_docs == 0) begin
                        n_docs = 1;
                    end
                    list_len = 4 * n_docs - $urandom_range(1, 3);
                end
                push_word(list_len);
                for (d = 0; d < n_docs; d++) begin
                    push_word(rand_word());
                end
            end
            if (flaw == FLAW_PARTIAL) begin
                push_noise($urandom_range(1, 15));
            end
            outer_len = rec_bytes.size() - 4;
            if (flaw == FLAW_LEN_OFF) begin
                if ($urandom_range(1) == 1) begin
                    outer_len = outer_len + $urandom_range(1, 8);
                end else begin
                    outer_len = outer_len - $urandom_range(1, 8);
                end
            end
            for (d = 0; d < 4; d++) begin
                rec_bytes[d] = outer_len[8*d +: 8];
            end
            if (flaw == FLAW_EXTRA) begin
                push_noise($urandom_range(1, 5));
            end
            if (flaw == FLAW_CUT) begin
                cut = $urandom_range(1, rec_bytes.size() - 1);
                repeat (cut) void'(rec_bytes.pop_back());
            end
        end
    endtask

    task automatic send_record();
        int k;
        for (k = 0; k < rec_bytes.size(); k++) begin
            while ($urandom_range(99) < send_idle_pct) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
            end
            i_valid     <= 1'b1;
            i_data_byte <= rec_bytes[k];
            i_last_byte <= (k == rec_bytes.size() - 1);
            @(posedge i_clk);
            while (o_stall) begin
                @(posedge i_clk);
            end
        end
        bytes_sent += rec_bytes.size();
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        wait (pending == 0);
    endtask

    initial begin : stimulus
        int    phase_no;
        t_flaw flaw;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // A stream ending inside the outer length word.
        rec_bytes = '{8'h00};
        send_record();
        // An empty record ends correctly.
        rec_bytes = '{8'h00, 8'h00, 8'h00, 8'h00};
        send_record();
        // A byte beyond an outer length of zero.
        rec_bytes = '{8'h00, 8'h00, 8'h00, 8'h00, 8'hff};
        send_record();
        // The largest outer length, never reached.
        rec_bytes = '{8'hff, 8'hff, 8'hff, 8'hff};
        send_record();
        drain();

        for (phase_no = 0; phase_no < 4; phase_no++) begin
            case (phase_no)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 68;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 68;
                end
                default: begin
                    send_idle_pct  = 27;
                    recv_stall_pct = 27;
                end
            endcase
            if (phase_no == 0 || phase_no == 3) begin
                hold_request++;
            end
            while (bytes_sent < (phase_no + 1) * ITEM_TARGET / 4) begin
                if ($urandom_range(99) < 60) begin
                    flaw = FLAW_NONE;
                end else begin
                    flaw = t_flaw'($urandom_range(FLAW_LEN_OFF, FLAW_NOISE));
                end
                build_record(flaw);
                send_record();
            end
            drain();
        end

        repeat (8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("** index_record_stream_decoder_top: PASSED **");
        end else begin
            $display("** index_record_stream_decoder_top: FAILED **");
        end
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("** index_record_stream_decoder_top: FAILED **");
        $finish;
    end

endmodule
